// ===== design/teal_pkg.sv =====
package teal_pkg;

	// Fixed field widths of the request and response words
	localparam int VERT_W     = 16;
	localparam int FACE_NUM_W = 8;
	localparam int LINKS_W    = 10;
	localparam int EDGES      = 3;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} teal_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NO_FACE = 2'd2
	} teal_status_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [VERT_W-1:0]     vert_first;
		logic [VERT_W-1:0]     vert_second;
		logic [VERT_W-1:0]     vert_third;
		logic [FACE_NUM_W-1:0] query_face;
		logic [1:0]            query_edge;
	} teal_in_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [FACE_NUM_W-1:0] face_number;
		logic [LINKS_W-1:0]    links_made;
		logic                  partner_valid;
		logic [FACE_NUM_W-1:0] partner_face;
		logic [1:0]            partner_edge;
		logic                  owner_side;
	} teal_out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start;
		logic load;
		logic qry_rd;
		logic qry_done;
		logic clr;
		logic fa_rd;
		logic fa_inc;
		logic row_a_ld;
		logic ea_clr;
		logic ea_inc;
		logic fb_clr;
		logic fb_rd;
		logic fb_inc;
		logic hit_ld;
		logic link_a;
		logic link_b;
		logic out_push;
	} teal_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic fa_end;
		logic ea_end;
		logic ea_linked;
		logic fb_end;
		logic hit;
		logic self_hit;
		logic out_free;
	} teal_sts_t;

endpackage

// ===== design/teal_ram.sv =====
module teal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one word, read one word with registered output
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/teal_ctrl.sv =====
module teal_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          opcode,
	output logic                req_stall,
	input  teal_pkg::teal_sts_t sts,
	output teal_pkg::teal_cmd_t cmd
);
	import teal_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE     = 13'h0001,
		S_LOAD     = 13'h0002,
		S_QRY_RD   = 13'h0004,
		S_QRY_DONE = 13'h0008,
		S_CLEAR    = 13'h0010,
		S_B_ORD    = 13'h0020,
		S_B_OWAIT  = 13'h0040,
		S_B_EDGE   = 13'h0080,
		S_B_SRD    = 13'h0100,
		S_B_SCMP   = 13'h0200,
		S_B_LNKA   = 13'h0400,
		S_B_LNKB   = 13'h0800,
		S_RESULT   = 13'h1000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	// Sequence the operations and the build search
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					case (opcode)
						OP_LOAD:  state_d = S_LOAD;
						OP_BUILD: state_d = S_B_ORD;
						OP_QUERY: state_d = S_QRY_RD;
						OP_CLEAR: state_d = S_CLEAR;
						default:  state_d = S_CLEAR;
					endcase
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_RESULT;
			end
			S_QRY_RD: begin
				cmd.qry_rd = 1'b1;
				state_d    = S_QRY_DONE;
			end
			S_QRY_DONE: begin
				cmd.qry_done = 1'b1;
				state_d      = S_RESULT;
			end
			S_CLEAR: begin
				cmd.clr = 1'b1;
				state_d = S_RESULT;
			end
			S_B_ORD: begin
				if (sts.fa_end) begin
					state_d = S_RESULT;
				end else begin
					cmd.fa_rd = 1'b1;
					state_d   = S_B_OWAIT;
				end
			end
			S_B_OWAIT: begin
				cmd.row_a_ld = 1'b1;
				cmd.ea_clr   = 1'b1;
				state_d      = S_B_EDGE;
			end
			S_B_EDGE: begin
				if (sts.ea_end) begin
					cmd.fa_inc = 1'b1;
					state_d    = S_B_ORD;
				end else if (sts.ea_linked) begin
					cmd.ea_inc = 1'b1;
				end else begin
					cmd.fb_clr = 1'b1;
					state_d    = S_B_SRD;
				end
			end
			S_B_SRD: begin
				if (sts.fb_end) begin
					cmd.ea_inc = 1'b1;
					state_d    = S_B_EDGE;
				end else begin
					cmd.fb_rd = 1'b1;
					state_d   = S_B_SCMP;
				end
			end
			S_B_SCMP: begin
				if (sts.hit) begin
					cmd.hit_ld = 1'b1;
					state_d    = S_B_LNKA;
				end else begin
					cmd.fb_inc = 1'b1;
					state_d    = S_B_SRD;
				end
			end
			S_B_LNKA: begin
				cmd.link_a = 1'b1;
				if (sts.self_hit) begin
					cmd.ea_inc = 1'b1;
					state_d    = S_B_EDGE;
				end else begin
					state_d = S_B_LNKB;
				end
			end
			S_B_LNKB: begin
				cmd.link_b = 1'b1;
				cmd.ea_inc = 1'b1;
				state_d    = S_B_EDGE;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/teal_dp.sv =====
module teal_dp #(
	parameter int MAX_FACES   = 256,
	parameter int VERTEX_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  teal_pkg::teal_in_t  req,
	input  teal_pkg::teal_cmd_t cmd,
	output teal_pkg::teal_sts_t sts,
	output teal_pkg::teal_out_t rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall
);
	import teal_pkg::*;

	localparam int FW = $clog2(MAX_FACES);
	localparam int CW = $clog2(MAX_FACES + 1);
	localparam int VW = (VERTEX_BITS < VERT_W) ? VERTEX_BITS : VERT_W;
	localparam int QW = (CW > FACE_NUM_W) ? CW : FACE_NUM_W;

	typedef struct packed {
		logic          valid;
		logic          owner;
		logic [FW-1:0] face;
		logic [1:0]    edge_idx;
	} link_t;

	typedef link_t [EDGES-1:0] link_row_t;
	typedef logic [EDGES-1:0][VW-1:0] vert_row_t;

	localparam int LRW = $bits(link_row_t);
	localparam int VRW = $bits(vert_row_t);

	// Control state
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      fa_q;
	logic [CW-1:0]      fb_q;
	logic [1:0]         ea_q;
	logic [LINKS_W-1:0] made_q;
	logic               rsp_valid_q;

	// Payload state
	teal_in_t  req_q;
	teal_out_t res_q;
	teal_out_t out_q;
	teal_out_t out_d;
	vert_row_t va_row_q;
	link_row_t la_row_q;
	link_row_t lb_row_q;
	logic [1:0] eb_hit_q;

	// Memory ports
	logic           v_wr_en, v_rd_en, l_wr_en, l_rd_en;
	logic [FW-1:0]  v_rd_addr, l_wr_addr, l_rd_addr;
	logic [VRW-1:0] v_wr_data, v_rd_data;
	logic [LRW-1:0] l_wr_data, l_rd_data;

	vert_row_t  vb_row, v_new;
	link_row_t  lb_row, new_a, new_b;
	logic       full;
	logic [VW-1:0] va0, va1;
	logic [EDGES-1:0] match;
	logic [1:0] eb_pick;
	logic       ea_linked;
	link_t      q_entry;
	logic       no_face;

	assign full   = (count_q == CW'(MAX_FACES));
	assign vb_row = vert_row_t'(v_rd_data);
	assign lb_row = link_row_t'(l_rd_data);

	// Vertex store: written on load, read by face during build
	assign v_new[0]  = VW'(req_q.vert_first);
	assign v_new[1]  = VW'(req_q.vert_second);
	assign v_new[2]  = VW'(req_q.vert_third);
	assign v_wr_en   = cmd.load && !full;
	assign v_wr_data = VRW'(v_new);
	assign v_rd_en   = cmd.fa_rd || cmd.fb_rd;
	assign v_rd_addr = cmd.fa_rd ? fa_q[FW-1:0] : fb_q[FW-1:0];

	teal_ram #(
		.WIDTH (VRW),
		.DEPTH (MAX_FACES)
	) u_vert_ram (
		.clk     (clk),
		.wr_en   (v_wr_en),
		.wr_addr (count_q[FW-1:0]),
		.wr_data (v_wr_data),
		.rd_en   (v_rd_en),
		.rd_addr (v_rd_addr),
		.rd_data (v_rd_data)
	);

	// Link store: a loaded face starts unlinked, build rewrites whole rows
	always_comb begin
		l_wr_en   = 1'b0;
		l_wr_addr = count_q[FW-1:0];
		l_wr_data = '0;
		if (cmd.load && !full) begin
			l_wr_en = 1'b1;
		end else if (cmd.link_a) begin
			l_wr_en   = 1'b1;
			l_wr_addr = fa_q[FW-1:0];
			l_wr_data = LRW'(new_a);
		end else if (cmd.link_b) begin
			l_wr_en   = 1'b1;
			l_wr_addr = fb_q[FW-1:0];
			l_wr_data = LRW'(new_b);
		end
	end

	assign l_rd_en   = cmd.qry_rd || cmd.fa_rd || cmd.fb_rd;
	assign l_rd_addr = cmd.qry_rd ? FW'(req_q.query_face) : v_rd_addr;

	teal_ram #(
		.WIDTH (LRW),
		.DEPTH (MAX_FACES)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (l_wr_en),
		.wr_addr (l_wr_addr),
		.wr_data (l_wr_data),
		.rd_en   (l_rd_en),
		.rd_addr (l_rd_addr),
		.rd_data (l_rd_data)
	);

	// Select the outer edge's endpoints and link state
	always_comb begin
		case (ea_q)
			2'd0: begin
				va0       = va_row_q[0];
				va1       = va_row_q[1];
				ea_linked = la_row_q[0].valid;
			end
			2'd1: begin
				va0       = va_row_q[1];
				va1       = va_row_q[2];
				ea_linked = la_row_q[1].valid;
			end
			2'd2: begin
				va0       = va_row_q[2];
				va1       = va_row_q[0];
				ea_linked = la_row_q[2].valid;
			end
			default: begin
				va0       = va_row_q[2];
				va1       = va_row_q[0];
				ea_linked = 1'b0;
			end
		endcase
	end

	// Look for the reversed, still unlinked edge among the edges of the scanned face
	assign match[0] = (va0 == vb_row[1]) && (va1 == vb_row[0]) && !lb_row[0].valid;
	assign match[1] = (va0 == vb_row[2]) && (va1 == vb_row[1]) && !lb_row[1].valid;
	assign match[2] = (va0 == vb_row[0]) && (va1 == vb_row[2]) && !lb_row[2].valid;
	assign eb_pick  = match[0] ? 2'd0 : (match[1] ? 2'd1 : 2'd2);

	// Build the new outer row (both ends when the faces are the same) and the new partner row
	always_comb begin
		new_a = la_row_q;
		for (int e = 0; e < EDGES; e++) begin
			if (2'(e) == ea_q) begin
				new_a[e].valid    = 1'b1;
				new_a[e].owner    = 1'b1;
				new_a[e].face     = fb_q[FW-1:0];
				new_a[e].edge_idx = eb_hit_q;
			end
		end
		if (fb_q == fa_q) begin
			for (int e = 0; e < EDGES; e++) begin
				if (2'(e) == eb_hit_q) begin
					new_a[e].valid    = 1'b1;
					new_a[e].owner    = 1'b1;
					new_a[e].face     = fa_q[FW-1:0];
					new_a[e].edge_idx = ea_q;
				end
			end
		end
	end

	always_comb begin
		new_b = lb_row_q;
		for (int e = 0; e < EDGES; e++) begin
			if (2'(e) == eb_hit_q) begin
				new_b[e].valid    = 1'b1;
				new_b[e].owner    = 1'b0;
				new_b[e].face     = fa_q[FW-1:0];
				new_b[e].edge_idx = ea_q;
			end
		end
	end

	// Pick the queried entry; edge three reads as unlinked
	always_comb begin
		q_entry = '0;
		for (int e = 0; e < EDGES; e++) begin
			if (2'(e) == req_q.query_edge) begin
				q_entry = lb_row[e];
			end
		end
	end

	assign no_face = (QW'(req_q.query_face) >= QW'(count_q));

	// Status toward the controller
	assign sts.fa_end    = (fa_q == count_q);
	assign sts.ea_end    = (ea_q == 2'(EDGES));
	assign sts.ea_linked = ea_linked;
	assign sts.fb_end    = (fb_q == count_q);
	assign sts.hit       = |match;
	assign sts.self_hit  = (fb_q == fa_q);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	// Counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fa_q        <= '0;
			fb_q        <= '0;
			ea_q        <= '0;
			made_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				fa_q   <= '0;
				made_q <= '0;
			end
			if (cmd.load && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.clr) begin
				count_q <= '0;
			end
			if (cmd.fa_inc) begin
				fa_q <= fa_q + CW'(1);
			end
			if (cmd.ea_clr) begin
				ea_q <= '0;
			end
			if (cmd.ea_inc) begin
				ea_q <= ea_q + 2'd1;
			end
			if (cmd.fb_clr) begin
				fb_q <= '0;
			end
			if (cmd.fb_inc) begin
				fb_q <= fb_q + CW'(1);
			end
			if (cmd.link_a) begin
				made_q <= made_q + LINKS_W'(1);
			end
			if (cmd.out_push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Merge the link count into the result word
	always_comb begin
		out_d            = res_q;
		out_d.links_made = made_q;
	end

	// Request word, result fields, row copies and output word
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
			res_q <= '0;
		end
		if (cmd.load) begin
			if (full) begin
				res_q.status <= ST_FULL;
			end else begin
				res_q.face_number <= FACE_NUM_W'(count_q);
			end
		end
		if (cmd.qry_done) begin
			if (no_face) begin
				res_q.status <= ST_NO_FACE;
			end else if (q_entry.valid) begin
				res_q.partner_valid <= 1'b1;
				res_q.partner_face  <= FACE_NUM_W'(q_entry.face);
				res_q.partner_edge  <= q_entry.edge_idx;
				res_q.owner_side    <= q_entry.owner;
			end
		end
		if (cmd.row_a_ld) begin
			va_row_q <= vb_row;
			la_row_q <= lb_row;
		end
		if (cmd.link_a) begin
			la_row_q <= new_a;
		end
		if (cmd.hit_ld) begin
			eb_hit_q <= eb_pick;
			lb_row_q <= lb_row;
		end
		if (cmd.out_push) begin
			out_q <= out_d;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/triangle_edge_adjacency_linker.sv =====
// Load and clear pass through one operation state, a query through a row read and a done
// state, then the result is pushed. Build: each loaded face is read and its rows copied,
// then its edges are taken in turn; an unlinked edge scans the loaded faces (row read of
// both memories, then compare) until a hit writes the link or the last face is passed.
// One word at a time; the next request is taken once the result sits in the output register.
// Reset: face count zero, no result pending; a face's link row is cleared when it is loaded.
module triangle_edge_adjacency_linker #(
	parameter int MAX_FACES   = 256,
	parameter int VERTEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  teal_pkg::teal_in_t req,
	input  logic               req_valid,
	output logic               req_stall,
	output teal_pkg::teal_out_t rsp,
	output logic               rsp_valid,
	input  logic               rsp_stall
);
	import teal_pkg::*;

	teal_cmd_t cmd;
	teal_sts_t sts;

	// Sequence operations
	teal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (req.opcode),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold tables, counters and the result word
	teal_dp #(
		.MAX_FACES   (MAX_FACES),
		.VERTEX_BITS (VERTEX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule
